// File: hdl/potb_pkg.sv
// Shared types and constants for the periodic/one-shot timer bank.
// Used by potb_mem and periodic_oneshot_timer_bank; no dependencies.
package potb_pkg;

  localparam int CntW = 32;  // count and interval width
  localparam int IdxW = 4;   // timer index field width
  localparam int CfgW = 5;   // active_timers register width
  localparam int CmdW = 2;   // command field width

  // Request opcodes; the unused code is ignored by the block
  typedef enum logic [CmdW-1:0] {
    CMD_TICK   = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_DISARM = 2'd2
  } cmd_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } state_t;

  // Write request into the timer store
  typedef struct packed {
    logic            cnt_en;
    logic            ivl_en;
    logic [CntW-1:0] cnt;
    logic [CntW-1:0] ivl;
  } wr_req_t;

endpackage

// File: hdl/potb_mem.sv
// Timer store: remaining-count and reload-interval memories with registered reads.
// Per-entry valid bits make never-armed entries read as zero after reset.
// Depends on potb_pkg.
module potb_mem #(
  parameter int TIMERS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [((TIMERS > 1) ? $clog2(TIMERS) : 1)-1:0] rd_addr,
  output logic [potb_pkg::CntW-1:0]     rd_cnt,
  output logic [potb_pkg::CntW-1:0]     rd_ivl,
  input  logic [((TIMERS > 1) ? $clog2(TIMERS) : 1)-1:0] wr_addr,
  input  potb_pkg::wr_req_t             wr
);

  logic [potb_pkg::CntW-1:0] cnt_mem [TIMERS];
  logic [potb_pkg::CntW-1:0] ivl_mem [TIMERS];
  logic [TIMERS-1:0]         vld_r;
  logic [potb_pkg::CntW-1:0] rd_cnt_r;
  logic [potb_pkg::CntW-1:0] rd_ivl_r;

  // Mark an entry valid once it has been armed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.ivl_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Write ports and registered reads; hold read data when no read is issued
  always_ff @(posedge clk) begin
    if (wr.cnt_en) begin
      cnt_mem[wr_addr] <= wr.cnt;
    end
    if (wr.ivl_en) begin
      ivl_mem[wr_addr] <= wr.ivl;
    end
    if (rd_en) begin
      rd_cnt_r <= vld_r[rd_addr] ? cnt_mem[rd_addr] : '0;
      rd_ivl_r <= vld_r[rd_addr] ? ivl_mem[rd_addr] : '0;
    end
  end

  assign rd_cnt = rd_cnt_r;
  assign rd_ivl = rd_ivl_r;

endmodule

// File: hdl/periodic_oneshot_timer_bank.sv
// Bank of countdown timers serviced by tick requests; top level.
// Depends on potb_pkg and potb_mem.
//
// Usage: requests enter on the in_ channel. in_tuser carries the command
// (tick, arm, disarm); in_tdata carries the timer index, timeout and
// interval. Arm and disarm produce nothing. A tick walks the N timers in
// service (active_timers, clamped to TIMERS) through the store, one timer per
// cycle unless stalled: a read is issued, the count comes back in the following
// cycle and is decremented and written back (reloaded from the interval on
// expiry). Each expiry leaves on the out_ channel with the timer index in
// out_tdata; the final expiry of a tick has out_tlast set. One expiry is held
// back until the next one (or the end of the walk) shows whether it is last.
// A tick occupies the block through its walk and flush, using the single read
// port of the store; the block accepts the next request only after that. A
// stalled receiver freezes the walk when a second expiry needs the output
// register. cfg_wr_en writes active_timers; the user must do so only while
// idle, the block does not enforce it. Reset clears the register, all counts
// and intervals (through per-entry valid bits), and the output channel.
module periodic_oneshot_timer_bank #(
  parameter int TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // timer_index[3:0], timeout[35:4], interval[67:36], zero
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // expired_index[3:0], zero
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int NW = ($clog2(TIMERS + 1) > potb_pkg::CfgW) ? $clog2(TIMERS + 1)
                                                            : potb_pkg::CfgW;

  potb_pkg::state_t               state_r, state_nxt;
  logic [potb_pkg::CfgW-1:0]      active_r;
  logic [NW-1:0]                  walk_r;
  logic                           p_valid_r;
  logic [AW-1:0]                  p_addr_r;
  logic                           hold_valid_r;
  logic [potb_pkg::IdxW-1:0]      hold_idx_r;
  logic                           out_tvalid_r;
  logic [potb_pkg::IdxW-1:0]      out_idx_r;
  logic                           out_last_r;

  potb_pkg::cmd_t                 in_cmd;
  logic [potb_pkg::IdxW-1:0]      in_idx;
  logic [potb_pkg::CntW-1:0]      in_tmo;
  logic [potb_pkg::CntW-1:0]      in_ivl;
  logic [NW-1:0]                  act_ext;
  logic [NW-1:0]                  n_use;
  logic [NW-1:0]                  idx_ext;
  logic                           idx_ok;
  logic                           in_acc;

  logic                           rd_en;
  logic [potb_pkg::CntW-1:0]      rd_cnt;
  logic [potb_pkg::CntW-1:0]      rd_ivl;
  logic [AW-1:0]                  wr_addr;
  potb_pkg::wr_req_t              wr;

  logic [potb_pkg::CntW-1:0]      p_dec;
  logic                           p_live;
  logic                           p_exp;
  logic                           out_free;
  logic                           stall;
  logic                           walk_more;
  logic                           push_mid;
  logic                           push_end;

  // Unpack the request; accept requests only while idle
  assign in_cmd    = potb_pkg::cmd_t'(in_tuser);
  assign in_idx    = in_tdata[3:0];
  assign in_tmo    = in_tdata[35:4];
  assign in_ivl    = in_tdata[67:36];
  assign in_tready = (state_r == potb_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Number of timers in service, clamped to the bank size
  assign act_ext = NW'(active_r);
  assign n_use   = (act_ext > NW'(TIMERS)) ? NW'(TIMERS) : act_ext;
  assign idx_ext = NW'(in_idx);
  assign idx_ok  = idx_ext < n_use;

  // Evaluate the entry whose read data arrived this cycle
  assign p_dec     = rd_cnt - 1'b1;
  assign p_live    = p_valid_r && (rd_cnt != '0);
  assign p_exp     = p_live && (p_dec == '0);
  assign out_free  = !out_tvalid_r || out_tready;
  assign stall     = p_exp && hold_valid_r && !out_free;
  assign walk_more = walk_r < n_use;
  assign rd_en     = (state_r == potb_pkg::S_WALK) && walk_more && !stall;
  assign push_mid  = p_exp && hold_valid_r && out_free;
  assign push_end  = (state_r == potb_pkg::S_FLUSH) && hold_valid_r && out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      potb_pkg::S_IDLE: begin
        if (in_acc && (in_cmd == potb_pkg::CMD_TICK)) begin
          state_nxt = potb_pkg::S_WALK;
        end
      end
      potb_pkg::S_WALK: begin
        if (!walk_more && !p_valid_r) begin
          state_nxt = potb_pkg::S_FLUSH;
        end
      end
      potb_pkg::S_FLUSH: begin
        if (!hold_valid_r || out_free) begin
          state_nxt = potb_pkg::S_IDLE;
        end
      end
      default: state_nxt = potb_pkg::S_IDLE;
    endcase
  end

  // Store write requests: arm/disarm while idle, count write-back while walking
  always_comb begin
    wr        = '0;
    wr_addr   = p_addr_r;
    unique case (state_r)
      potb_pkg::S_IDLE: begin
        wr_addr   = idx_ext[AW-1:0];
        if (in_acc && idx_ok) begin
          unique case (in_cmd)
            potb_pkg::CMD_ARM: begin
              wr.cnt_en = 1'b1;
              wr.ivl_en = 1'b1;
              wr.cnt    = in_tmo;
              wr.ivl    = in_ivl;
            end
            potb_pkg::CMD_DISARM: begin
              wr.cnt_en = 1'b1;
            end
            default: wr = '0;
          endcase
        end
      end
      potb_pkg::S_WALK: begin
        if (p_live && !stall) begin
          wr.cnt_en = 1'b1;
          wr.cnt    = p_exp ? rd_ivl : p_dec;
        end
      end
      default: wr = '0;
    endcase
  end

  potb_mem #(
    .TIMERS (TIMERS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (walk_r[AW-1:0]),
    .rd_cnt  (rd_cnt),
    .rd_ivl  (rd_ivl),
    .wr_addr (wr_addr),
    .wr      (wr)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= potb_pkg::S_IDLE;
      active_r     <= '0;
      walk_r       <= '0;
      p_valid_r    <= 1'b0;
      hold_valid_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
      // Restart the walk on a tick, advance per issued read
      if (in_acc && (in_cmd == potb_pkg::CMD_TICK)) begin
        walk_r <= '0;
      end else if (rd_en) begin
        walk_r <= walk_r + 1'b1;
      end
      if (!stall) begin
        p_valid_r <= rd_en;
      end
      // Hold the newest expiry until its successor or the walk end is known
      if (p_exp && !stall) begin
        hold_valid_r <= 1'b1;
      end else if (push_end) begin
        hold_valid_r <= 1'b0;
      end
      if (push_mid || push_end) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      p_addr_r <= walk_r[AW-1:0];
    end
    if (p_exp && !stall) begin
      hold_idx_r <= potb_pkg::IdxW'(p_addr_r);
    end
    if (push_mid || push_end) begin
      out_idx_r  <= hold_idx_r;
      out_last_r <= push_end;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(8 - potb_pkg::IdxW){1'b0}}, out_idx_r};
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  // Idle means the walk pipeline and the held expiry are empty
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == potb_pkg::S_IDLE) |-> (!p_valid_r && !hold_valid_r))
    else $error("idle with work still in flight");

  // A stalled evaluation must not issue a new read
  a_stall_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    stall |-> !rd_en)
    else $error("read issued during stall");

  // The walk never passes the number of timers in service
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == potb_pkg::S_WALK) |-> (walk_r <= n_use))
    else $error("walk ran past active timers");

  // Draining the held expiry at the end of a tick emits a last-flagged result
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    push_end |=> (out_tvalid && out_tlast))
    else $error("final expiry not flagged last");

  // A mid-walk push never carries the last flag
  a_mid_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    push_mid |=> (out_tvalid && !out_tlast))
    else $error("mid-walk expiry flagged last");
`endif

endmodule

// File: sim/periodic_oneshot_timer_bank_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for periodic_oneshot_timer_bank: arm, disarm and tick requests
// checked against an in-bench timer bank model. Depends on potb_pkg and the RTL only.
module periodic_oneshot_timer_bank_tb;

  localparam int NumTimers = 16;
  localparam int IdleWait  = 40;  // covers a full walk of the bank plus pipeline
  localparam logic [potb_pkg::CmdW-1:0] CmdUnused = 2'd3;

  typedef struct {
    logic [potb_pkg::CmdW-1:0] cmd;
    logic [potb_pkg::IdxW-1:0] idx;
    logic [potb_pkg::CntW-1:0] timeout;
    logic [potb_pkg::CntW-1:0] interval;
  } timer_req_t;

  typedef struct {
    logic [potb_pkg::IdxW-1:0] index;
    logic                      last;
  } expiry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;    // timer_index[3:0], timeout[35:4], interval[67:36], zero
  logic [1:0]  in_tuser = '0;    // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // expired_index[3:0], zero
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;

  // Timer bank model
  logic [potb_pkg::CfgW-1:0] active_model;
  logic [potb_pkg::CntW-1:0] count_model [NumTimers];
  logic [potb_pkg::CntW-1:0] reload_model[NumTimers];
  expiry_t                   expiry_q[$];

  timer_req_t      pending_q[$];
  int unsigned     issued_cnt = 0;
  int unsigned     accepted_cnt = 0;
  int unsigned     fail_cnt = 0;

  periodic_oneshot_timer_bank #(.TIMERS(NumTimers)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one accepted request to the model and queue the expiries it causes
  function automatic void predict_request(timer_req_t r);
    int unsigned               serviced;
    logic [potb_pkg::IdxW-1:0] hits[$];
    serviced = (active_model > NumTimers) ? NumTimers : active_model;
    case (r.cmd)
      potb_pkg::CMD_ARM: begin
        if (r.idx < serviced) begin
          count_model[r.idx]  = r.timeout;
          reload_model[r.idx] = r.interval;
        end
      end
      potb_pkg::CMD_DISARM: begin
        if (r.idx < serviced) count_model[r.idx] = '0;
      end
      potb_pkg::CMD_TICK: begin
        for (int i = 0; i < serviced; i++) begin
          if (count_model[i] != 0) begin
            count_model[i] = count_model[i] - 1;
            if (count_model[i] == 0) begin
              hits.push_back(potb_pkg::IdxW'(i));
              count_model[i] = reload_model[i];
            end
          end
        end
        foreach (hits[k]) expiry_q.push_back('{hits[k], k == hits.size() - 1});
      end
      default: ;  // unused code: drop
    endcase
  endfunction

  function automatic timer_req_t random_request(int unsigned serviced);
    timer_req_t  r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)      r.cmd = potb_pkg::CMD_TICK;
    else if (pick < 80) r.cmd = potb_pkg::CMD_ARM;
    else if (pick < 93) r.cmd = potb_pkg::CMD_DISARM;
    else                r.cmd = CmdUnused;
    // Mostly address timers in use, sometimes any index
    if (serviced > 0 && $urandom_range(0, 9) < 8)
      r.idx = potb_pkg::IdxW'($urandom_range(0, serviced - 1));
    else
      r.idx = potb_pkg::IdxW'($urandom_range(0, NumTimers - 1));
    case ($urandom_range(0, 9))
      0:       r.timeout = '0;
      1:       r.timeout = $urandom();
      default: r.timeout = $urandom_range(1, 6);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: r.interval = '0;
      3:       r.interval = $urandom();
      default: r.interval = $urandom_range(1, 5);
    endcase
    return r;
  endfunction

  task automatic push_request(input logic [potb_pkg::CmdW-1:0] cmd, input int unsigned idx,
                              input logic [potb_pkg::CntW-1:0] tmo,
                              input logic [potb_pkg::CntW-1:0] ivl);
    timer_req_t r;
    r = '{cmd, potb_pkg::IdxW'(idx), tmo, ivl};
    pending_q.push_back(r);
    issued_cnt++;
  endtask

  // Hold until every request is taken and every expiry has arrived, then let the walk finish
  task automatic wait_idle();
    while (accepted_cnt != issued_cnt || expiry_q.size() != 0) @(posedge clk);
    repeat (IdleWait) @(posedge clk);
  endtask

  task automatic write_active(input logic [potb_pkg::CfgW-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    active_model = value;
  endtask

  // Request driver: bursts of random length separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  timer_req_t  cur_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_request(cur_req);
        accepted_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_req = pending_q.pop_front();
          in_tdata  <= {4'b0, cur_req.interval, cur_req.timeout, cur_req.idx};
          in_tuser  <= cur_req.cmd;
          in_tvalid <= 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 16);
          burst_left--;
          if (burst_left == 0) begin
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(1, 2);
              2:       gap_left = $urandom_range(3, 8);
              default: gap_left = $urandom_range(9, 24);
            endcase
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: the ready mode is picked at random from four modes
  int unsigned ready_mode = 0;
  int unsigned ready_tick = 0;

  always @(posedge clk) begin
    ready_tick++;
    if (ready_tick % 32 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (ready_tick % 4 == 0);
      default: out_tready <= (ready_tick % 8 == 7);
    endcase
  end

  // Expiry monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    expiry_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expiry_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("ERROR %0t: unexpected expiry index=%0d last=%0b",
                   $realtime, out_tdata[potb_pkg::IdxW-1:0], out_tlast);
      end else begin
        want = expiry_q.pop_front();
        if (out_tdata[potb_pkg::IdxW-1:0] !== want.index || out_tlast !== want.last) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("ERROR %0t: expiry mismatch exp index=%0d last=%0b, got index=%0d last=%0b",
                     $realtime, want.index, want.last, out_tdata[potb_pkg::IdxW-1:0],
                     out_tlast);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [potb_pkg::CfgW-1:0] phase_cfg[7];
    int unsigned               serviced;
    int unsigned               n_items;
    timer_req_t                rnd_req;

    active_model = '0;
    foreach (count_model[i]) begin
      count_model[i]  = '0;
      reload_model[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // No timers in use: everything is ignored
    write_active(5'd0);
    push_request(potb_pkg::CMD_ARM, 0, 32'd1, 32'd1);
    push_request(potb_pkg::CMD_TICK, 0, '0, '0);
    push_request(CmdUnused, 15, '1, '1);
    wait_idle();

    // Oversized register: all timers serviced, one-shot, periodic and extremes
    write_active(5'd31);
    push_request(potb_pkg::CMD_ARM, 15, 32'd1, 32'd0);
    push_request(potb_pkg::CMD_ARM, 0, 32'd1, 32'd2);
    push_request(potb_pkg::CMD_ARM, 3, 32'd2, 32'd1);
    push_request(potb_pkg::CMD_ARM, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(potb_pkg::CMD_ARM, 5, 32'd0, 32'd3);
    push_request(potb_pkg::CMD_TICK, 9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(potb_pkg::CMD_TICK, 0, '0, '0);
    push_request(potb_pkg::CMD_TICK, 0, '0, '0);
    push_request(potb_pkg::CMD_DISARM, 3, '0, '0);
    push_request(potb_pkg::CMD_DISARM, 15, '0, '0);
    push_request(CmdUnused, 0, '0, '0);
    push_request(potb_pkg::CMD_TICK, 0, '0, '0);
    push_request(potb_pkg::CMD_ARM, 9, 32'd1, 32'hFFFF_FFFF);
    push_request(potb_pkg::CMD_TICK, 0, '0, '0);
    wait_idle();

    // Shrink the active range: upper timers keep their state
    write_active(5'd4);
    push_request(potb_pkg::CMD_ARM, 8, 32'd1, 32'd1);
    push_request(potb_pkg::CMD_DISARM, 9, '0, '0);
    push_request(potb_pkg::CMD_TICK, 0, '0, '0);
    push_request(potb_pkg::CMD_TICK, 0, '0, '0);
    wait_idle();

    // Random phases over several register settings
    phase_cfg = '{5'd16, 5'd1, potb_pkg::CfgW'($urandom_range(2, 15)), 5'd31, 5'd0,
                  potb_pkg::CfgW'($urandom_range(2, 15)), 5'd16};
    foreach (phase_cfg[p]) begin
      write_active(phase_cfg[p]);
      serviced = (phase_cfg[p] > NumTimers) ? NumTimers : phase_cfg[p];
      n_items  = (serviced == 0) ? 8 : 50;
      repeat (n_items) begin
        rnd_req = random_request(serviced);
        push_request(rnd_req.cmd, rnd_req.idx, rnd_req.timeout, rnd_req.interval);
      end
      wait_idle();
    end

    if (expiry_q.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
